@@ hw/rtl/sdr_pkg.sv @@
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants for the SPIR-V descriptor reflector: opcodes,
// decoration and storage codes, stage and error codes, the command that the
// front passes to the back, and the id table entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

  localparam int ID_DEPTH_DEF = 1024;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);

  localparam logic [31:0] MAGIC_WORD = 32'h0723_0203;
  localparam logic [2:0]  HDR_WORDS  = 3'd5;
  localparam logic [2:0]  HDR_BOUND  = 3'd3;

  localparam logic [15:0] OP_ENTRY    = 16'd15;
  localparam logic [15:0] OP_VARIABLE = 16'd59;
  localparam logic [15:0] OP_DECORATE = 16'd71;

  localparam logic [31:0] DEC_BINDING = 32'd33;
  localparam logic [31:0] DEC_SET     = 32'd34;
  localparam logic [31:0] SC_UNIFORM  = 32'd2;
  localparam logic [31:0] BIND_LIMIT  = 32'd32;

  localparam logic [31:0] EM_VERTEX   = 32'd0;
  localparam logic [31:0] EM_FRAGMENT = 32'd4;
  localparam logic [31:0] EM_TASK     = 32'd5267;
  localparam logic [31:0] EM_MESH     = 32'd5268;

  localparam logic [2:0] STG_NONE     = 3'd0;
  localparam logic [2:0] STG_VERTEX   = 3'd1;
  localparam logic [2:0] STG_FRAGMENT = 3'd2;
  localparam logic [2:0] STG_TASK     = 3'd3;
  localparam logic [2:0] STG_MESH     = 3'd4;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_MAGIC    = 4'd1;
  localparam logic [3:0] ERR_ID_RANGE = 4'd2;
  localparam logic [3:0] ERR_SHORT    = 4'd3;
  localparam logic [3:0] ERR_OVERRUN  = 4'd4;
  localparam logic [3:0] ERR_DUP_VAR  = 4'd5;
  localparam logic [3:0] ERR_STAGE    = 4'd6;
  localparam logic [3:0] ERR_SET      = 4'd7;
  localparam logic [3:0] ERR_BINDING  = 4'd8;
  localparam logic [3:0] ERR_DUP_BIND = 4'd9;

  localparam logic [15:0] LEN_ENTRY   = 16'd2;
  localparam logic [15:0] LEN_DEC_MIN = 16'd3;
  localparam logic [15:0] LEN_DEC_OP  = 16'd4;
  localparam logic [15:0] LEN_VAR     = 16'd4;

  typedef struct packed {
    logic [3:0]       flag;      // header or framing error seen on this word
    logic             exec;      // an instruction completed on this word
    logic [15:0]      opcode;
    logic [15:0]      len;
    logic [2:0][31:0] ops;       // instruction words 1..3
    logic [1:0]       ok;        // ops[0], ops[1] are in-range ids
    logic             done;      // last word of the module
    logic             overrun;   // module ended inside header or instruction
    logic [31:0]      id_cap;
  } cmd_t;

  typedef struct packed {
    logic [4:0] bind_lo;
    logic       big_bind;
    logic       set_nz;
    logic       is_uni;
    logic       is_var;
  } entry_t;

  function automatic logic [3:0] err_pick(input logic [3:0] cur, input logic [3:0] code);
    return (cur != ERR_OK) ? cur : code;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sdr_front.sv @@
// ----------------------------------------------------------------------------
// sdr_front
// Word parser: checks the header, frames instructions by word count, gathers
// the first three operands and pushes one command per word that matters.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_front import sdr_pkg::*; #(
  parameter int ID_DEPTH = ID_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] code_word,
  input  wire logic        last_word,
  input  wire logic        cmd_room,
  input  wire logic        back_ready,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic [2:0]       word_index, word_index_next;
  logic [31:0]      id_limit, id_limit_next;
  logic [15:0]      words_left, words_left_next;
  logic [15:0]      instr_opcode, instr_opcode_next;
  logic [15:0]      instr_len, instr_len_next;
  logic [2:0][31:0] operand_regs, operand_regs_next;
  logic [1:0]       op_ok, op_ok_next;
  logic [2:0]       op_pos, op_pos_next;
  logic             acc;
  logic             word_ok;
  logic [15:0]      cnt;

  assign in_ready = cmd_room & back_ready;
  assign acc      = in_valid & in_ready;
  assign word_ok  = (code_word < id_limit) && (code_word < 32'(ID_DEPTH));
  assign cnt      = code_word[31:16];

  always_comb begin
    word_index_next   = word_index;
    id_limit_next     = id_limit;
    words_left_next   = words_left;
    instr_opcode_next = instr_opcode;
    instr_len_next    = instr_len;
    operand_regs_next = operand_regs;
    op_ok_next        = op_ok;
    op_pos_next       = op_pos;
    cmd               = '0;

    if (word_index < HDR_WORDS) begin
      if (word_index == 3'd0 && code_word != MAGIC_WORD) cmd.flag = ERR_MAGIC;
      if (word_index == HDR_BOUND) id_limit_next = code_word;
      word_index_next = word_index + 3'd1;
    end else if (words_left == 16'd0) begin
      if (cnt == 16'd0) begin
        cmd.flag = ERR_SHORT;
      end else begin
        instr_opcode_next = code_word[15:0];
        instr_len_next    = cnt;
        operand_regs_next = '0;
        op_ok_next        = '0;
        op_pos_next       = 3'd1;
        words_left_next   = cnt - 16'd1;
        if (cnt == 16'd1) cmd.exec = 1'b1;
      end
    end else begin
      if (op_pos <= 3'd3) begin
        operand_regs_next[op_pos[1:0] - 2'd1] = code_word;
        if (op_pos == 3'd1) op_ok_next[0] = word_ok;
        if (op_pos == 3'd2) op_ok_next[1] = word_ok;
        op_pos_next = op_pos + 3'd1;
      end
      words_left_next = words_left - 16'd1;
      if (words_left_next == 16'd0) cmd.exec = 1'b1;
    end

    cmd.opcode = instr_opcode_next;
    cmd.len    = instr_len_next;
    cmd.ops    = operand_regs_next;
    cmd.ok     = op_ok_next;

    if (last_word) begin
      cmd.done     = 1'b1;
      cmd.overrun  = (word_index_next < HDR_WORDS) || (words_left_next != 16'd0);
      cmd.id_cap   = id_limit_next;
      // start the next module from scratch
      word_index_next   = '0;
      id_limit_next     = '0;
      words_left_next   = '0;
      instr_opcode_next = '0;
      instr_len_next    = '0;
      operand_regs_next = '0;
      op_ok_next        = '0;
      op_pos_next       = '0;
    end
  end

  assign cmd_push = acc && (cmd.flag != ERR_OK || cmd.exec || last_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= '0;
      id_limit     <= '0;
      words_left   <= '0;
      instr_opcode <= '0;
      instr_len    <= '0;
      operand_regs <= '0;
      op_ok        <= '0;
      op_pos       <= '0;
    end else if (acc) begin
      word_index   <= word_index_next;
      id_limit     <= id_limit_next;
      words_left   <= words_left_next;
      instr_opcode <= instr_opcode_next;
      instr_len    <= instr_len_next;
      operand_regs <= operand_regs_next;
      op_ok        <= op_ok_next;
      op_pos       <= op_pos_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sdr_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// sdr_cmd_fifo
// Short command queue between the parser and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_cmd_fifo import sdr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      room,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      dout
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   count;

  assign room  = count != (CMD_PTR_W+1)'(CMD_DEPTH);
  assign valid = count != '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sdr_back.sv @@
// ----------------------------------------------------------------------------
// sdr_back
// Table engine: executes instructions against the id table with a
// read-modify-write, tracks stage and first error, scans and clears the
// table at the end of each module and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_back import sdr_pkg::*; #(
  parameter int ID_DEPTH = ID_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [31:0] buffer_mask,
  output logic [2:0]  stage_code,
  output logic [3:0]  error_code
);

  localparam int AW = $clog2(ID_DEPTH);
  localparam int PW = AW + 1;

  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_UPD, ST_SCAN, ST_FIN} state_t;

  state_t          state, state_next;
  cmd_t            cur, cur_next;
  entry_t          mem [ID_DEPTH];
  entry_t          rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;
  logic [PW-1:0]   scan_ptr, scan_ptr_next;
  logic [PW-1:0]   scan_n, scan_n_next;
  logic            scan_v, scan_v_next;
  logic [31:0]     mask_acc, mask_acc_next;
  logic [2:0]      stage_reg, stage_reg_next;
  logic [3:0]      first_error, first_error_next;
  logic            out_valid_next;
  logic [31:0]     out_mask_next;
  logic [2:0]      out_stage_next;
  logic [3:0]      out_err_next;
  logic            need_mem;
  logic [AW-1:0]   cmd_id, cur_id;
  entry_t          e_new;
  logic [31:0]     bit_sel;
  logic [PW-1:0]   bound_n;

  assign ready   = state != ST_INIT;
  assign cmd_id  = (cmd.opcode == OP_VARIABLE) ? cmd.ops[1][AW-1:0] : cmd.ops[0][AW-1:0];
  assign cur_id  = (cur.opcode == OP_VARIABLE) ? cur.ops[1][AW-1:0] : cur.ops[0][AW-1:0];
  assign bit_sel = 32'd1 << rdata.bind_lo;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    scan_ptr_next    = scan_ptr;
    scan_n_next      = scan_n;
    scan_v_next      = 1'b0;
    mask_acc_next    = mask_acc;
    stage_reg_next   = stage_reg;
    first_error_next = first_error;
    out_valid_next   = out_valid && !out_ready;
    out_mask_next    = buffer_mask;
    out_stage_next   = stage_code;
    out_err_next     = error_code;
    cmd_pop          = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = scan_ptr[AW-1:0];
    mem_wdata        = '0;
    mem_raddr        = '0;
    need_mem         = 1'b0;
    e_new            = rdata;
    bound_n          = '0;

    unique case (state)
      ST_INIT: begin
        mem_we        = 1'b1;
        scan_ptr_next = scan_ptr + 1'b1;
        if (scan_ptr == PW'(ID_DEPTH - 1)) begin
          scan_ptr_next = '0;
          state_next    = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop          = 1'b1;
          cur_next         = cmd;
          mem_raddr        = cmd_id;
          bound_n          = (cmd.id_cap < 32'(ID_DEPTH)) ? cmd.id_cap[PW-1:0]
                                                          : PW'(ID_DEPTH);
          first_error_next = err_pick(first_error_next, cmd.flag);
          if (cmd.exec) begin
            case (cmd.opcode)
              OP_ENTRY: begin
                if (cmd.len < LEN_ENTRY) begin
                  first_error_next = err_pick(first_error_next, ERR_SHORT);
                end else begin
                  case (cmd.ops[0])
                    EM_VERTEX:   stage_reg_next = STG_VERTEX;
                    EM_FRAGMENT: stage_reg_next = STG_FRAGMENT;
                    EM_TASK:     stage_reg_next = STG_TASK;
                    EM_MESH:     stage_reg_next = STG_MESH;
                    default: begin
                      stage_reg_next   = STG_NONE;
                      first_error_next = err_pick(first_error_next, ERR_STAGE);
                    end
                  endcase
                end
              end
              OP_DECORATE: begin
                if (cmd.len < LEN_DEC_MIN) begin
                  first_error_next = err_pick(first_error_next, ERR_SHORT);
                end else if (cmd.ops[1] != DEC_SET && cmd.ops[1] != DEC_BINDING) begin
                  if (!cmd.ok[0]) first_error_next = err_pick(first_error_next, ERR_ID_RANGE);
                end else if (cmd.len < LEN_DEC_OP) begin
                  first_error_next = err_pick(first_error_next, ERR_SHORT);
                end else if (!cmd.ok[0]) begin
                  first_error_next = err_pick(first_error_next, ERR_ID_RANGE);
                end else begin
                  need_mem = 1'b1;
                end
              end
              OP_VARIABLE: begin
                if (cmd.len < LEN_VAR) begin
                  first_error_next = err_pick(first_error_next, ERR_SHORT);
                end else if (!cmd.ok[1]) begin
                  first_error_next = err_pick(first_error_next, ERR_ID_RANGE);
                end else begin
                  need_mem = 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (need_mem) begin
            state_next = ST_UPD;
          end else if (cmd.done) begin
            if (cmd.overrun) first_error_next = err_pick(first_error_next, ERR_OVERRUN);
            scan_n_next   = bound_n;
            scan_ptr_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end

      ST_UPD: begin
        // table entry arrived: modify and write back
        if (cur.opcode == OP_VARIABLE) begin
          if (rdata.is_var) first_error_next = err_pick(first_error_next, ERR_DUP_VAR);
          e_new.is_var = 1'b1;
          e_new.is_uni = cur.ops[2] == SC_UNIFORM;
        end else if (cur.ops[1] == DEC_SET) begin
          e_new.set_nz = cur.ops[2] != 32'd0;
        end else begin
          e_new.big_bind = cur.ops[2] >= BIND_LIMIT;
          e_new.bind_lo  = (cur.ops[2] >= BIND_LIMIT) ? 5'd0 : cur.ops[2][4:0];
        end
        mem_we     = 1'b1;
        mem_waddr  = cur_id;
        mem_wdata  = e_new;
        bound_n    = (cur.id_cap < 32'(ID_DEPTH)) ? cur.id_cap[PW-1:0] : PW'(ID_DEPTH);
        state_next = ST_IDLE;
        if (cur.done) begin
          if (cur.overrun) first_error_next = err_pick(first_error_next, ERR_OVERRUN);
          scan_n_next   = bound_n;
          scan_ptr_next = '0;
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read and clear one entry per cycle, evaluate it in the next cycle
        if (scan_ptr < scan_n) begin
          mem_raddr     = scan_ptr[AW-1:0];
          mem_we        = 1'b1;
          scan_ptr_next = scan_ptr + 1'b1;
          scan_v_next   = 1'b1;
        end else if (!scan_v) begin
          state_next = ST_FIN;
        end
        if (scan_v && rdata.is_var && rdata.is_uni) begin
          if (rdata.set_nz) first_error_next = err_pick(first_error_next, ERR_SET);
          if (rdata.big_bind) begin
            first_error_next = err_pick(first_error_next, ERR_BINDING);
          end else begin
            if ((mask_acc & bit_sel) != 32'd0) begin
              first_error_next = err_pick(first_error_next, ERR_DUP_BIND);
            end
            mask_acc_next = mask_acc | bit_sel;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          out_mask_next    = mask_acc;
          out_stage_next   = stage_reg;
          out_err_next     = first_error;
          mask_acc_next    = '0;
          stage_reg_next   = STG_NONE;
          first_error_next = ERR_OK;
          state_next       = ST_IDLE;
        end
      end

      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      scan_ptr    <= '0;
      scan_n      <= '0;
      scan_v      <= 1'b0;
      mask_acc    <= '0;
      stage_reg   <= STG_NONE;
      first_error <= ERR_OK;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      scan_ptr    <= scan_ptr_next;
      scan_n      <= scan_n_next;
      scan_v      <= scan_v_next;
      mask_acc    <= mask_acc_next;
      stage_reg   <= stage_reg_next;
      first_error <= first_error_next;
      out_valid   <= out_valid_next;
    end
    cur         <= cur_next;
    buffer_mask <= out_mask_next;
    stage_code  <= out_stage_next;
    error_code  <= out_err_next;
  end

  a_first_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (first_error != ERR_OK && state != ST_FIN) |=> first_error == $past(first_error))
    else $error("first error overwritten");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_INIT || state == ST_UPD || state == ST_SCAN))
    else $error("table written outside init, update or scan");

  a_scan_pipe: assert property (@(posedge clk) disable iff (rst)
    scan_v |-> state == ST_SCAN)
    else $error("scan data pending outside scan");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE && cmd_valid)
    else $error("command taken while busy");

endmodule

`default_nettype wire

@@ hw/rtl/spirv_descriptor_reflector.sv @@
// ----------------------------------------------------------------------------
// spirv_descriptor_reflector
// Streams a SPIR-V module in one 32-bit word per item (s_tlast on the final
// word) and returns one item per module: the binding mask of Uniform variables,
// the shader stage and the first error found.
//
// The parser front accepts one word per cycle while its 4-entry command
// queue has room and the table engine is ready. The table engine handles
// most commands in its idle state; a well-formed Set/Binding Decorate or
// Variable also passes through an update state (read-modify-write of the id
// table, one port each way). After s_tlast the engine scans and clears
// min(id bound, ID_DEPTH) table entries, one per cycle. Words of the
// next module are parsed into the queue during the scan.
// After rst the table is cleared, one entry per cycle, and s_tready stays
// low until that is done. The result sits in an output register; while
// m_tready is low the engine holds the next result back and the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module spirv_descriptor_reflector import sdr_pkg::*; #(
  parameter int ID_DEPTH = ID_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] code_word
  input  wire logic        s_tlast,   // last_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [31:0] buffer_mask, [34:32] stage_code,
                                      // [38:35] error_code, [39] zero
);

  cmd_t        push_cmd, head_cmd;
  logic        cmd_push, cmd_pop, cmd_room, cmd_valid;
  logic        back_ready;
  logic [31:0] buffer_mask;
  logic [2:0]  stage_code;
  logic [3:0]  error_code;

  sdr_front #(.ID_DEPTH(ID_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .code_word  (s_tdata),
    .last_word  (s_tlast),
    .cmd_room   (cmd_room),
    .back_ready (back_ready),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd)
  );

  sdr_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (push_cmd),
    .room  (cmd_room),
    .pop   (cmd_pop),
    .valid (cmd_valid),
    .dout  (head_cmd)
  );

  sdr_back #(.ID_DEPTH(ID_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .ready       (back_ready),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .buffer_mask (buffer_mask),
    .stage_code  (stage_code),
    .error_code  (error_code)
  );

  assign m_tdata = {1'b0, error_code, stage_code, buffer_mask};

endmodule

`default_nettype wire

@@ dv/spirv_descriptor_reflector_tb.sv @@
// ----------------------------------------------------------------------------
// spirv_descriptor_reflector_tb
// Feeds SPIR-V modules word by word into the reflector: a short table of
// hand-built modules, then random modules that are mostly well formed. Each
// reflection item (binding mask, stage, first error) of a hand-built module is
// checked against the value in the table, and of a random module against a
// behavioral model of the header check, the instruction walk, the id table
// and the end-of-module scan. Sender and receiver throttle at random.
`default_nettype none

module spirv_descriptor_reflector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdr_pkg::*;

  localparam int TBL_DEPTH   = ID_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = TBL_DEPTH + 16;
  localparam int PHASE_WORDS = 383;
  localparam int LONG_HOLD   = 600;

  typedef struct packed {
    logic [31:0] mask;
    logic [2:0]  stage;
    logic [3:0]  err;
  } reflect_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        typed;
    reflect_t    want;
  } dir_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles   = 0;
  int unsigned cycle_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned modules_sent  = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  logic [15:0] err_seen      = '0;

  reflect_t pending_reflections [$];

  // parser and id table state of the model
  logic [2:0]  hdr_seen;
  logic [31:0] model_bound;
  logic [15:0] words_due;
  logic [15:0] cur_op;
  logic [15:0] cur_len;
  logic [31:0] cur_args [3];
  logic [2:0]  cur_stage;
  logic [3:0]  first_err;
  entry_t      id_tbl [TBL_DEPTH];

  spirv_descriptor_reflector #(
    .ID_DEPTH(TBL_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic note_err(input logic [3:0] code);
    if (first_err == ERR_OK) first_err = code;
  endtask

  function automatic logic id_fits(input logic [31:0] id);
    return id < model_bound && id < TBL_DEPTH;
  endfunction

  task automatic clear_model();
    hdr_seen    = '0;
    model_bound = '0;
    words_due   = '0;
    cur_op      = '0;
    cur_len     = '0;
    foreach (cur_args[i]) cur_args[i] = '0;
    cur_stage = STG_NONE;
    first_err = ERR_OK;
    foreach (id_tbl[i]) id_tbl[i] = '0;
  endtask

  task automatic retire_instr();
    logic [31:0] id;
    id = '0;
    case (cur_op)
      OP_ENTRY: begin
        if (cur_len < LEN_ENTRY) begin
          note_err(ERR_SHORT);
        end else begin
          case (cur_args[0])
            EM_VERTEX:   cur_stage = STG_VERTEX;
            EM_FRAGMENT: cur_stage = STG_FRAGMENT;
            EM_TASK:     cur_stage = STG_TASK;
            EM_MESH:     cur_stage = STG_MESH;
            default: begin
              note_err(ERR_STAGE);
              cur_stage = STG_NONE;
            end
          endcase
        end
      end
      OP_DECORATE: begin
        id = cur_args[0];
        if (cur_len < LEN_DEC_MIN) begin
          note_err(ERR_SHORT);
        end else if (cur_args[1] != DEC_SET && cur_args[1] != DEC_BINDING) begin
          // other decorations only get their target id checked
          if (!id_fits(id)) note_err(ERR_ID_RANGE);
        end else if (cur_len < LEN_DEC_OP) begin
          note_err(ERR_SHORT);
        end else if (!id_fits(id)) begin
          note_err(ERR_ID_RANGE);
        end else if (cur_args[1] == DEC_SET) begin
          id_tbl[id].set_nz = (cur_args[2] != '0);
        end else begin
          id_tbl[id].big_bind = (cur_args[2] >= BIND_LIMIT);
          id_tbl[id].bind_lo  = (cur_args[2] >= BIND_LIMIT) ? 5'd0 : cur_args[2][4:0];
        end
      end
      OP_VARIABLE: begin
        id = cur_args[1];
        if (cur_len < LEN_VAR) begin
          note_err(ERR_SHORT);
        end else if (!id_fits(id)) begin
          note_err(ERR_ID_RANGE);
        end else begin
          if (id_tbl[id].is_var) note_err(ERR_DUP_VAR);
          id_tbl[id].is_var = 1'b1;
          id_tbl[id].is_uni = (cur_args[2] == SC_UNIFORM);
        end
      end
      default: ;
    endcase
  endtask

  // Advance the model by one accepted word; on the last word scan the table
  // and return the reflection of the module.
  task automatic reflect_word(input logic [31:0] w, input logic l,
                              output logic fired, output reflect_t res);
    logic [15:0] pos;
    logic [31:0] bit_sel;
    int unsigned span;
    fired = 1'b0;
    res   = '0;
    if (hdr_seen < HDR_WORDS) begin
      if (hdr_seen == 3'd0 && w != MAGIC_WORD) note_err(ERR_MAGIC);
      if (hdr_seen == HDR_BOUND) model_bound = w;
      hdr_seen = hdr_seen + 3'd1;
    end else if (words_due == '0) begin
      if (w[31:16] == '0) begin
        // zero word count: flag it and treat the word as a whole instruction
        note_err(ERR_SHORT);
      end else begin
        cur_op  = w[15:0];
        cur_len = w[31:16];
        foreach (cur_args[i]) cur_args[i] = '0;
        words_due = w[31:16] - 16'd1;
        if (words_due == '0) retire_instr();
      end
    end else begin
      pos = cur_len - words_due;
      if (pos >= 16'd1 && pos <= 16'd3) cur_args[pos - 16'd1] = w;
      words_due = words_due - 16'd1;
      if (words_due == '0) retire_instr();
    end
    if (l) begin
      if (hdr_seen < HDR_WORDS || words_due != '0) note_err(ERR_OVERRUN);
      span = (model_bound < TBL_DEPTH) ? model_bound : TBL_DEPTH;
      for (int i = 0; i < span; i++) begin
        if (!(id_tbl[i].is_var && id_tbl[i].is_uni)) continue;
        if (id_tbl[i].set_nz) note_err(ERR_SET);
        if (id_tbl[i].big_bind) begin
          note_err(ERR_BINDING);
          continue;
        end
        bit_sel = 32'd1 << id_tbl[i].bind_lo;
        if ((res.mask & bit_sel) != '0) note_err(ERR_DUP_BIND);
        res.mask = res.mask | bit_sel;
      end
      res.stage = cur_stage;
      res.err   = first_err;
      fired     = 1'b1;
      clear_model();
    end
  endtask

  task automatic send_word(input logic [31:0] w, input logic l, input logic typed,
                           input reflect_t want);
    reflect_t res;
    logic     fired;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    reflect_word(w, l, fired, res);
    if (fired) begin
      modules_sent++;
      pending_reflections.insert(pending_reflections.size(), typed ? want : res);
    end
  endtask

  // Mostly in-range ids from a small pool so duplicates are common; some
  // land on the table edge or anywhere.
  function automatic logic [31:0] pick_id(input logic [31:0] bound);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom();
    if (r < 14) return TBL_DEPTH - 1 + $urandom_range(0, 1);
    if (bound == '0) return $urandom_range(0, 3);
    return $urandom_range(0, (bound > 40) ? 40 : bound);
  endfunction

  // receiver: random backpressure, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_reflections
    reflect_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      err_seen[m_tdata[38:35]] = 1'b1;
      if (pending_reflections.size() == 0) begin
        report_mismatch("item with nothing expected", m_tdata[31:0], '0);
      end else begin
        want = pending_reflections.pop_front();
        if (m_tdata[31:0] != want.mask) begin
          report_mismatch("buffer_mask", m_tdata[31:0], want.mask);
        end
        if (m_tdata[34:32] != want.stage) begin
          report_mismatch("stage_code", m_tdata[34:32], want.stage);
        end
        if (m_tdata[38:35] != want.err) begin
          report_mismatch("error_code", m_tdata[38:35], want.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding",
               cycle_count, pending_reflections.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    logic [31:0] mod_words [$];
    logic [31:0] plan [3];
    logic [31:0] bound_w;
    logic [15:0] opc;
    int unsigned n_instr;
    int unsigned kind;
    int unsigned cnt;
    int unsigned r;
    int unsigned phase_start;

    clear_model();
    send_idle_pct = 26;
    recv_idle_pct = 78;

    // all-ones word: bad magic, and the module ends inside the header
    rows.insert(rows.size(), dir_row_t'{32'hFFFF_FFFF, 1'b1, 1'b1,
                                        reflect_t'{32'h0, STG_NONE, ERR_MAGIC}});
    // good magic alone: module ends inside the header
    rows.insert(rows.size(), dir_row_t'{MAGIC_WORD, 1'b1, 1'b1,
                                        reflect_t'{32'h0, STG_NONE, ERR_OVERRUN}});
    // fragment entry, Uniform variable id 3 at binding 31
    rows.insert(rows.size(), dir_row_t'{MAGIC_WORD,   1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'd16,       1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{{LEN_ENTRY, OP_ENTRY}, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{EM_FRAGMENT,  1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{{LEN_VAR, OP_VARIABLE}, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'd3,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{SC_UNIFORM,   1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{{LEN_DEC_OP, OP_DECORATE}, 1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'd3,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{DEC_BINDING,  1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'd31,       1'b1, 1'b1,
                                        reflect_t'{32'h8000_0000, STG_FRAGMENT, ERR_OK}});
    // zero id bound, then a zero word count on the last word
    rows.insert(rows.size(), dir_row_t'{MAGIC_WORD,   1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b0, 1'b0, '0});
    rows.insert(rows.size(), dir_row_t'{32'h0,        1'b1, 1'b1,
                                        reflect_t'{32'h0, STG_NONE, ERR_SHORT}});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].word, rows[i].last, rows[i].typed, rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // hold the output so results back up and the input stalls
          hold_cycles = LONG_HOLD;
        end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        mod_words.delete();
        mod_words.insert(mod_words.size(),
                         ($urandom_range(0, 99) < 6) ? $urandom() : MAGIC_WORD);
        mod_words.insert(mod_words.size(), $urandom());
        mod_words.insert(mod_words.size(), $urandom());
        r = $urandom_range(0, 99);
        if (r < 4) bound_w = $urandom();
        else if (r < 8) bound_w = '0;
        else if (r < 11) bound_w = TBL_DEPTH + $urandom_range(0, 8);
        else bound_w = $urandom_range(1, 40);
        mod_words.insert(mod_words.size(), bound_w);
        mod_words.insert(mod_words.size(), $urandom());
        n_instr = $urandom_range(0, 10);
        repeat (n_instr) begin
          kind = $urandom_range(0, 99);
          r    = $urandom_range(0, 99);
          cnt  = (r < 10) ? $urandom_range(1, 3) : (r < 18) ? $urandom_range(5, 6) : 4;
          foreach (plan[i]) plan[i] = $urandom();
          opc = '0;
          if (kind < 15) begin
            opc = OP_ENTRY;
            cnt = (r < 8) ? 1 : $urandom_range(2, 5);
            case ($urandom_range(0, 4))
              0: plan[0] = EM_VERTEX;
              1: plan[0] = EM_FRAGMENT;
              2: plan[0] = EM_TASK;
              3: plan[0] = EM_MESH;
              default: ;  // keep the random word, an unknown model
            endcase
          end else if (kind < 45) begin
            opc     = OP_DECORATE;
            plan[0] = pick_id(bound_w);
            r       = $urandom_range(0, 99);
            plan[1] = (r < 45) ? DEC_BINDING : (r < 85) ? DEC_SET : $urandom_range(0, 40);
            r       = $urandom_range(0, 99);
            if (plan[1] == DEC_BINDING) begin
              plan[2] = (r < 85) ? $urandom_range(0, 31)
                      : (r < 93) ? $urandom_range(32, 40) : $urandom();
            end else begin
              plan[2] = (r < 70) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom();
            end
          end else if (kind < 80) begin
            opc     = OP_VARIABLE;
            plan[1] = pick_id(bound_w);
            plan[2] = ($urandom_range(0, 99) < 75) ? SC_UNIFORM : $urandom_range(0, 12);
          end else if (kind < 92) begin
            opc = 16'($urandom_range(0, 400));
            cnt = $urandom_range(1, 5);
          end
          if (kind < 92) begin
            mod_words.insert(mod_words.size(), {cnt[15:0], opc});
            for (int k = 1; k < cnt; k++) begin
              mod_words.insert(mod_words.size(), (k <= 3) ? plan[k - 1] : $urandom());
            end
          end else if (kind < 96) begin
            mod_words.insert(mod_words.size(), {16'h0000, plan[0][15:0]});
          end else begin
            mod_words.insert(mod_words.size(), $urandom());
          end
        end
        // cut some modules short at a random word, which can fall inside the header or an instruction
        if ($urandom_range(0, 99) < 6) begin
          cnt = $urandom_range(1, mod_words.size());
          while (mod_words.size() > cnt) void'(mod_words.pop_back());
        end
        foreach (mod_words[k]) begin
          send_word(mod_words[k], k == mod_words.size() - 1, 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_reflections.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Streamed %0d words in %0d modules, %0d reflection items checked",
             words_sent, modules_sent, results_seen);
    $display("Error codes returned, one bit per code from 0 up: %b", err_seen[9:0]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
